@@ rtl/ccp_pkg.sv @@
// Shared types and constants for the ciphertext compress-and-pack unit.
// Used by ccp_front, ccp_fifo, ccp_back and the top level.
package ccp_pkg;

  localparam int POLY_LEN   = 256;
  localparam int MAX_RANK   = 4;
  localparam int IDX_W      = $clog2((MAX_RANK + 1) * POLY_LEN);
  localparam int RANK_W     = 3;
  localparam int COEFF_W    = 12;
  localparam int BYTE_W     = 8;
  localparam int CODE_W_U   = 11;
  localparam int CODE_W_V   = 5;
  localparam int ACC_W      = 18;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [RANK_W-1:0]  RANK_RESET = 3'd4;
  localparam logic [COEFF_W-1:0] MODULUS_Q  = 12'd3329;

  // Barrett multipliers; both carry trailing zeros, so they are reduced to a
  // common shift of 22 with the rounding term 2^21.
  localparam longint unsigned MUL_D11    = 64'd5284526080;
  localparam longint unsigned MUL_D5     = 64'd1290176;
  localparam int              PROD_SHIFT = 22;
  localparam int              PROD_W     = 34;
  localparam int              K_W        = 22;
  localparam logic [K_W-1:0]  K_U        = K_W'(MUL_D11 >> 11);
  localparam logic [K_W-1:0]  K_V        = K_W'(MUL_D5 >> 5);
  localparam logic [PROD_W-1:0] ROUND_TERM = PROD_W'(64'd1 << (PROD_SHIFT - 1));

  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic               is_u;
    logic               is_last;
  } ccp_item_t;

  typedef struct packed {
    logic      valid;
    ccp_item_t item;
  } ccp_xfer_t;

endpackage

@@ rtl/ccp_front.sv @@
// Front end: accepts coefficients, clamps them and classifies each as u, v
// or final v by the running index and live rank. Depends on ccp_pkg.
module ccp_front import ccp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [RANK_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COEFF_W-1:0] in_coefficient,
  input  logic               fifo_full,
  output ccp_xfer_t          push
);

  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [RANK_W-1:0] rank_live;
  logic [IDX_W-1:0]  u_total;
  logic [IDX_W-1:0]  last_pos;
  logic              accept;
  logic              is_last;
  logic [COEFF_W-1:0] coeff_clamped;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  always_comb begin
    rank_live = rank_r;
    if (rank_r == '0) begin
      rank_live = RANK_W'(1);
    end else if (rank_r > RANK_W'(MAX_RANK)) begin
      rank_live = RANK_W'(MAX_RANK);
    end
  end

  assign u_total  = IDX_W'(rank_live) * IDX_W'(POLY_LEN);
  assign last_pos = u_total + IDX_W'(POLY_LEN - 1);
  assign is_last  = idx_r >= last_pos;

  assign coeff_clamped = (in_coefficient >= MODULUS_Q) ? (MODULUS_Q - 12'd1)
                                                       : in_coefficient;

  assign push.valid        = accept;
  assign push.item.coeff   = coeff_clamped;
  assign push.item.is_u    = !is_last && (idx_r < u_total);
  assign push.item.is_last = is_last;

  always_comb begin
    rank_nxt = cfg_wr_en ? cfg_wr_data : rank_r;
    idx_nxt  = idx_r;
    if (accept) begin
      // wrap after the final v coefficient
      idx_nxt = is_last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_RESET;
      idx_r  <= '0;
    end else begin
      rank_r <= rank_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

@@ rtl/ccp_fifo.sv @@
// Short queue of classified items between front and back end.
// Depends on ccp_pkg.
module ccp_fifo import ccp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ccp_xfer_t push,
  output logic      full,
  output ccp_xfer_t head,
  input  logic      pop
);

  ccp_item_t          mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;

  assign full       = count_r == (PTR_W+1)'(FIFO_DEPTH);
  assign head.valid = count_r != '0;
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push.valid, pop})
      2'b10:   count_nxt = count_r + (PTR_W+1)'(1);
      2'b01:   count_nxt = count_r - (PTR_W+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/ccp_back.sv @@
// Back end: Barrett compression (one registered multiply), bit packing into
// bytes and a two-byte output buffer. Depends on ccp_pkg.
module ccp_back import ccp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ccp_xfer_t         head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_cipher_byte,
  output logic              out_last
);

  // multiply stage
  logic                m_v_r, m_v_nxt;
  logic [CODE_W_U-1:0] m_code_r, m_code_nxt;
  logic                m_is_u_r, m_is_last_r;
  logic [K_W-1:0]      mul_k;
  logic [PROD_W-1:0]   prod;

  // packing state
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [ACC_W-1:0]    acc_new;
  logic [ACC_W-1:0]    acc_shift;
  logic [4:0]          code_w;
  logic [4:0]          cnt_new;
  logic [4:0]          rem;
  logic [1:0]          n_full;
  logic [1:0]          n_tot;
  logic                flush;

  // output buffer
  logic [BYTE_W-1:0]   pb0_r, pb1_r, pb0_nxt, pb1_nxt;
  logic                pl0_r, pl1_r, pl0_nxt, pl1_nxt;
  logic [1:0]          pc_r, pc_nxt;
  logic                out_take;
  logic                pack_fire;

  assign out_valid       = pc_r != 2'd0;
  assign out_cipher_byte = pb0_r;
  assign out_last        = pl0_r;
  assign out_take        = out_valid && !out_stall;

  // take a new item once the buffer drains to at most one byte being taken
  assign pack_fire = m_v_r && ((pc_r == 2'd0) || ((pc_r == 2'd1) && out_take));
  assign pop       = head.valid && (!m_v_r || pack_fire);

  assign mul_k = head.item.is_u ? K_U : K_V;
  assign prod  = PROD_W'(head.item.coeff) * PROD_W'(mul_k) + ROUND_TERM;

  always_comb begin
    m_v_nxt    = m_v_r;
    m_code_nxt = m_code_r;
    if (pop) begin
      m_v_nxt = 1'b1;
      if (head.item.is_u) begin
        m_code_nxt = prod[PROD_SHIFT+CODE_W_U-1:PROD_SHIFT];
      end else begin
        m_code_nxt = CODE_W_U'(prod[PROD_SHIFT+CODE_W_V-1:PROD_SHIFT]);
      end
    end else if (pack_fire) begin
      m_v_nxt = 1'b0;
    end
  end

  always_comb begin
    code_w    = m_is_u_r ? 5'(CODE_W_U) : 5'(CODE_W_V);
    acc_new   = acc_r | (ACC_W'(m_code_r) << cnt_r);
    cnt_new   = {2'b00, cnt_r} + code_w;
    if (cnt_new >= 5'd16) begin
      n_full = 2'd2;
    end else if (cnt_new >= 5'd8) begin
      n_full = 2'd1;
    end else begin
      n_full = 2'd0;
    end
    rem       = cnt_new - {n_full, 3'b000};
    // final coefficient: flush leftover bits as a zero-padded byte
    flush     = m_is_last_r && (rem != 5'd0);
    n_tot     = n_full + {1'b0, flush};
    acc_shift = acc_new >> {n_full, 3'b000};

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pb0_nxt = pb0_r;
    pb1_nxt = pb1_r;
    pl0_nxt = pl0_r;
    pl1_nxt = pl1_r;
    pc_nxt  = pc_r;
    if (pack_fire) begin
      acc_nxt = m_is_last_r ? '0 : acc_shift;
      cnt_nxt = m_is_last_r ? 3'd0 : rem[2:0];
      pb0_nxt = acc_new[7:0];
      pb1_nxt = acc_new[15:8];
      pl0_nxt = m_is_last_r && (n_tot == 2'd1);
      pl1_nxt = m_is_last_r && (n_tot == 2'd2);
      pc_nxt  = n_tot;
    end else if (out_take) begin
      // advance the second byte to the head
      pb0_nxt = pb1_r;
      pl0_nxt = pl1_r;
      pc_nxt  = pc_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    m_code_r <= m_code_nxt;
    pb0_r    <= pb0_nxt;
    pb1_r    <= pb1_nxt;
    pl0_r    <= pl0_nxt;
    pl1_r    <= pl1_nxt;
    if (pop) begin
      m_is_u_r    <= head.item.is_u;
      m_is_last_r <= head.item.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      acc_r <= '0;
      cnt_r <= '0;
      pc_r  <= '0;
    end else begin
      m_v_r <= m_v_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pc_r  <= pc_nxt;
    end
  end

  // bits above the fill level stay zero, so padding of the flush is clean
  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> cnt_r) == '0)
    else $error("packer holds stray bits above its fill level");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pack_fire && m_is_last_r |=> (acc_r == '0) && (cnt_r == 3'd0) && pc_r != 2'd0)
    else $error("final item did not clear packer or produced no byte");

  a_buf_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != 2'd0) && out_stall |=> $stable(pb0_r) && $stable(pl0_r) && $stable(pc_r))
    else $error("output buffer changed while stalled");

endmodule

@@ rtl/lattice_ciphertext_compress_pack_unit.sv @@
// Top level of the ciphertext compress-and-pack unit.
// Instantiates ccp_front, ccp_fifo and ccp_back; depends on ccp_pkg.
//
// Usage: send rank*256 u coefficients, then 256 v coefficients, on the in_
// channel (valid/stall). Each u coefficient is compressed to 11 bits, each v
// coefficient to 5 bits, and the packed bytes leave LSB-first on the out_
// channel, one byte per cycle while out_stall is low, with out_last on the
// final ciphertext byte. The user must write the rank register through
// cfg_wr_en/cfg_wr_data only while idle; the block itself does not enforce it.
// Path: an accepted coefficient is written into the queue, moves from the
// queue into the multiply stage register and is then loaded into the output
// buffer; its first byte is shown from then on and is taken when not stalled.
// Throughput: one coefficient per cycle is taken while the four-entry queue
// has room; sustained rate is set by the byte output, one byte per cycle
// while out_stall is low, so a code that yields two bytes delays the next
// code's load into the output buffer until its second byte is taken.
// Reset (rst_n low, synchronous) empties the queue and packer, sets the index
// to zero and the rank to 4. When the receiver stalls, the output byte holds;
// the packer and then the queue fill, and in_stall rises when the queue is full.
module lattice_ciphertext_compress_pack_unit import ccp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [RANK_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COEFF_W-1:0] in_coefficient,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_cipher_byte,
  output logic               out_last
);

  ccp_xfer_t push;
  ccp_xfer_t head;
  logic      fifo_full;
  logic      pop;

  ccp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coefficient (in_coefficient),
    .fifo_full      (fifo_full),
    .push           (push)
  );

  ccp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (fifo_full),
    .head  (head),
    .pop   (pop)
  );

  ccp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_byte (out_cipher_byte),
    .out_last        (out_last)
  );

endmodule
